// ===== design/assert_macros.svh =====
// Assertion helpers included by wfba_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WFBA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WFBA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wfba_pkg.sv =====
package wfba_pkg;

  localparam int BLOCKS_DEF    = 64;
  localparam int SIZE_BITS_DEF = 16;

  // Field widths of the channels
  localparam int OP_W       = 1;
  localparam int LIDX_W     = 6;
  localparam int REQ_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int CHOSEN_W   = 6;
  localparam int REM_W      = 16;
  localparam int FRAG_W     = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SHARE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] COUNT_RST = 7'd64;
  localparam logic [FRAG_W-1:0]     SUM_MAX   = 22'h3FFFFF;

endpackage

// ===== design/wfba_intf.sv =====
interface wfba_req_if;
  import wfba_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [LIDX_W-1:0]   load_index;
  logic [REQ_W-1:0]    size_value;

  modport source (output valid, output operation, output load_index, output size_value,
                  input ready);
  modport sink   (input valid, input operation, input load_index, input size_value,
                  output ready);
endinterface

interface wfba_rsp_if;
  import wfba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHOSEN_W-1:0] chosen_block;
  logic [REM_W-1:0]    remaining_size;
  logic [FRAG_W-1:0]   internal_frag;
  logic [FRAG_W-1:0]   external_frag;

  modport source (output valid, output status, output chosen_block, output remaining_size,
                  output internal_frag, output external_frag, input ready);
  modport sink   (input valid, input status, input chosen_block, input remaining_size,
                  input internal_frag, input external_frag, output ready);
endinterface

interface wfba_cfg_if;
  import wfba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/wfba_cell.sv =====
module wfba_cell #(
  parameter int  BLOCKS    = wfba_pkg::BLOCKS_DEF,
  parameter int  SIZE_BITS = wfba_pkg::SIZE_BITS_DEF,
  parameter int  J         = 0,
  parameter type pkt_t     = logic,
  parameter type wr_t      = logic,
  parameter type scan_t    = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  scan_t scan_i,
  input  wr_t   wr_i,
  input  pkt_t  pkt_i,
  output pkt_t  pkt_o
);
  import wfba_pkg::*;

  localparam int IW = $clog2(BLOCKS);
  localparam int AW = SIZE_BITS + $clog2(BLOCKS);
  localparam int NW = ($clog2(BLOCKS + 1) > CFG_DATA_W) ? $clog2(BLOCKS + 1) : CFG_DATA_W;

  logic [SIZE_BITS-1:0] size_q;
  logic                 occ_q;
  logic                 active;
  logic                 qual;
  pkt_t                 pkt_d;
  pkt_t                 pkt_q;

  assign active = NW'(J) < scan_i.count;
  assign qual   = active && (scan_i.share || !occ_q) && (size_q >= scan_i.req_size);

  always_comb begin
    pkt_d = pkt_i;
    if (pkt_i.valid && active) begin
      if (occ_q) begin
        pkt_d.inner = pkt_i.inner + AW'(size_q);
      end else begin
        pkt_d.outer = pkt_i.outer + AW'(size_q);
      end
      // >= keeps the highest index on a tie
      if (qual && (!pkt_i.found || size_q >= pkt_i.best_size)) begin
        pkt_d.found     = 1'b1;
        pkt_d.best_idx  = IW'(J);
        pkt_d.best_size = size_q;
        pkt_d.best_occ  = occ_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      occ_q  <= 1'b0;
    end else if (wr_i.we && wr_i.idx == IW'(J)) begin
      size_q <= wr_i.size;
      occ_q  <= wr_i.occ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

// ===== design/wfba_ctrl.sv =====
`include "assert_macros.svh"

module wfba_ctrl #(
  parameter int  BLOCKS    = wfba_pkg::BLOCKS_DEF,
  parameter int  SIZE_BITS = wfba_pkg::SIZE_BITS_DEF,
  parameter type pkt_t     = logic,
  parameter type wr_t      = logic,
  parameter type scan_t    = logic
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wfba_cfg_if.sink   cfg_i,
  wfba_req_if.sink   req_i,
  wfba_rsp_if.source rsp_o,
  output pkt_t       pkt_o,
  input  pkt_t       pkt_i,
  output wr_t        wr_o,
  output scan_t      scan_o
);
  import wfba_pkg::*;

  localparam int IW = $clog2(BLOCKS);
  localparam int AW = SIZE_BITS + $clog2(BLOCKS);
  localparam int NW = ($clog2(BLOCKS + 1) > CFG_DATA_W) ? $clog2(BLOCKS + 1) : CFG_DATA_W;
  localparam int CW = (AW + 1 > FRAG_W) ? AW + 1 : FRAG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  function automatic logic [FRAG_W-1:0] sat_sum(input logic [AW:0] v);
    if (CW'(v) > CW'(SUM_MAX)) begin
      return SUM_MAX;
    end
    return FRAG_W'(v);
  endfunction

  logic [1:0]            state_q, state_d;
  logic                  start_q;
  logic                  share_q;
  logic [CFG_DATA_W-1:0] count_q;
  logic [NW-1:0]         count;
  logic                  acc;
  logic                  in_range;
  logic                  scan_done;

  logic [OP_W-1:0]       op_q;
  logic [LIDX_W-1:0]     idx_q;
  logic [SIZE_BITS-1:0]  req_q;
  logic                  inrng_q;

  logic [SIZE_BITS-1:0]  left;
  logic [AW:0]           inner_adj;
  logic [AW:0]           outer_adj;
  logic [STATUS_W-1:0]   res_status_d, res_status_q;
  logic [CHOSEN_W-1:0]   res_chosen_d, res_chosen_q;
  logic [REM_W-1:0]      res_rem_d, res_rem_q;
  logic [FRAG_W-1:0]     res_inner_d, res_inner_q;
  logic [FRAG_W-1:0]     res_outer_d, res_outer_q;

  logic                  out_valid_q;
  logic                  out_load;
  logic [STATUS_W-1:0]   out_status_q;
  logic [CHOSEN_W-1:0]   out_chosen_q;
  logic [REM_W-1:0]      out_rem_q;
  logic [FRAG_W-1:0]     out_inner_q;
  logic [FRAG_W-1:0]     out_outer_q;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      share_q <= 1'b0;
      count_q <= COUNT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SHARE: share_q <= cfg_i.data[0];
        REG_COUNT: count_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign count = (NW'(count_q) > NW'(BLOCKS)) ? NW'(BLOCKS) : NW'(count_q);

  assign scan_o.share    = share_q;
  assign scan_o.count    = count;
  assign scan_o.req_size = req_q;

  // Request side
  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign in_range    = NW'(req_i.load_index) < count;
  assign scan_done   = (state_q == ST_SCAN) && pkt_i.valid;

  always_comb begin
    pkt_o       = '0;
    pkt_o.valid = start_q;
  end

  assign left = pkt_i.best_size - req_q;

  // Table writes: an in-range load at accept, a grant as the scan exits the chain
  always_comb begin
    wr_o      = '0;
    if (acc && req_i.operation == OP_LOAD && in_range) begin
      wr_o.we   = 1'b1;
      wr_o.idx  = IW'(req_i.load_index);
      wr_o.size = SIZE_BITS'(req_i.size_value);
      wr_o.occ  = 1'b0;
    end else if (scan_done && op_q == OP_ALLOC && pkt_i.found) begin
      wr_o.we   = 1'b1;
      wr_o.idx  = pkt_i.best_idx;
      wr_o.size = left;
      wr_o.occ  = 1'b1;
    end
  end

  // The chain sums the table before the grant; move the granted block over here
  always_comb begin
    inner_adj = {1'b0, pkt_i.inner} + (AW + 1)'(left);
    outer_adj = {1'b0, pkt_i.outer};
    if (pkt_i.best_occ) begin
      inner_adj = inner_adj - (AW + 1)'(pkt_i.best_size);
    end else begin
      outer_adj = outer_adj - (AW + 1)'(pkt_i.best_size);
    end
  end

  always_comb begin
    res_status_d = STATUS_DONE;
    res_chosen_d = '0;
    res_rem_d    = '0;
    res_inner_d  = sat_sum({1'b0, pkt_i.inner});
    res_outer_d  = sat_sum({1'b0, pkt_i.outer});
    if (op_q == OP_LOAD) begin
      if (inrng_q) begin
        res_chosen_d = idx_q;
        res_rem_d    = REM_W'(req_q);
      end else begin
        res_status_d = STATUS_BAD_INDEX;
      end
    end else if (pkt_i.found) begin
      res_chosen_d = CHOSEN_W'(pkt_i.best_idx);
      res_rem_d    = REM_W'(left);
      res_inner_d  = sat_sum(inner_adj);
      res_outer_d  = sat_sum(outer_adj);
    end else begin
      res_status_d = STATUS_NO_FIT;
    end
  end

  assign out_load = (state_q == ST_HOLD) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc)       state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_HOLD;
      ST_HOLD: if (out_load)  state_d = ST_IDLE;
      default:                state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= acc;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q    <= req_i.operation;
      idx_q   <= req_i.load_index;
      req_q   <= SIZE_BITS'(req_i.size_value);
      inrng_q <= in_range;
    end
    if (scan_done) begin
      res_status_q <= res_status_d;
      res_chosen_q <= res_chosen_d;
      res_rem_q    <= res_rem_d;
      res_inner_q  <= res_inner_d;
      res_outer_q  <= res_outer_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_chosen_q <= res_chosen_q;
      out_rem_q    <= res_rem_q;
      out_inner_q  <= res_inner_q;
      out_outer_q  <= res_outer_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.chosen_block   = out_chosen_q;
  assign rsp_o.remaining_size = out_rem_q;
  assign rsp_o.internal_frag  = out_inner_q;
  assign rsp_o.external_frag  = out_outer_q;

  `WFBA_ASSERT_IMP(a_start_after_accept, start_q, state_q == ST_SCAN && $past(acc),
                   "scan started without an accepted request")
  `WFBA_ASSERT_IMP(a_scan_out_in_scan, pkt_i.valid, state_q == ST_SCAN,
                   "scan packet left the chain outside the scan state")
  `WFBA_ASSERT_IMP(a_no_write_in_hold, wr_o.we, state_q != ST_HOLD,
                   "table written while a result is held")
  `WFBA_ASSERT_NXT(a_hold_to_output, out_load, out_valid_q && state_q == ST_IDLE,
                   "held result did not move to the output register")

endmodule

// ===== design/worst_fit_block_allocator.sv =====
// Worst-fit block allocator.
// Channels: req_i takes requests (operation, load_index, size_value); rsp_o returns
// one result per request (status, chosen_block, remaining_size, internal_frag,
// external_frag); cfg_i writes share_mode (index 0) and blocks_in_use (index 1),
// always ready; the user must write cfg_i only while no request is in flight, and the
// block does not enforce it. A load writes one table entry and marks it free; an
// allocate grants the largest fitting block in use, a free one unless share_mode is
// 1 (highest index on a tie), and shrinks it by the request. Every request, load or
// allocate, sends one scan packet down a chain of BLOCKS cells, one cell per cycle;
// each cell owns one table entry and, if in use, adds it to the fragmentation sums
// and competes for the grant. The packet passes the cell registers into the result
// register; the next request is taken once the result is in the output register.
// A stalled rsp_o keeps the result in the output register; one more result may
// wait behind it, and req_i stays low-ready until the output frees up.
// Reset (rst_ni low, asynchronous) clears the table to size zero and all free,
// share_mode to 0 and blocks_in_use to 64; no clearing pass is needed.
module worst_fit_block_allocator #(
  parameter int BLOCKS    = wfba_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wfba_cfg_if.sink   cfg_i,
  wfba_req_if.sink   req_i,
  wfba_rsp_if.source rsp_o
);
  import wfba_pkg::*;

  localparam int IW = $clog2(BLOCKS);
  localparam int AW = SIZE_BITS + $clog2(BLOCKS);
  localparam int NW = ($clog2(BLOCKS + 1) > CFG_DATA_W) ? $clog2(BLOCKS + 1) : CFG_DATA_W;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [IW-1:0]        best_idx;
    logic [SIZE_BITS-1:0] best_size;
    logic                 best_occ;
    logic [AW-1:0]        inner;
    logic [AW-1:0]        outer;
  } pkt_t;

  typedef struct packed {
    logic                 we;
    logic [IW-1:0]        idx;
    logic [SIZE_BITS-1:0] size;
    logic                 occ;
  } wr_t;

  typedef struct packed {
    logic                 share;
    logic [NW-1:0]        count;
    logic [SIZE_BITS-1:0] req_size;
  } scan_t;

  pkt_t  chain [BLOCKS+1];
  wr_t   wr;
  scan_t scan;

  wfba_ctrl #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS),
    .pkt_t     (pkt_t),
    .wr_t      (wr_t),
    .scan_t    (scan_t)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .pkt_o  (chain[0]),
    .pkt_i  (chain[BLOCKS]),
    .wr_o   (wr),
    .scan_o (scan)
  );

  for (genvar j = 0; j < BLOCKS; j++) begin : g_cell
    wfba_cell #(
      .BLOCKS    (BLOCKS),
      .SIZE_BITS (SIZE_BITS),
      .J         (j),
      .pkt_t     (pkt_t),
      .wr_t      (wr_t),
      .scan_t    (scan_t)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .scan_i (scan),
      .wr_i   (wr),
      .pkt_i  (chain[j]),
      .pkt_o  (chain[j+1])
    );
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import wfba_pkg::*;

  localparam int BLOCKS       = BLOCKS_DEF;
  localparam int RANDOM_ITEMS = 1630;
  localparam int PHASES       = 12;
  localparam int QUIET_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 100;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CHOSEN_W-1:0] chosen;
    logic [REM_W-1:0]    remaining;
    logic [FRAG_W-1:0]   inner;
    logic [FRAG_W-1:0]   outer;
  } grant_t;

  // Mirror of the block table plus the queue of grants still owed by the block.
  class alloc_tracker;
    logic [REQ_W-1:0]      sizes [BLOCKS];
    bit                    taken [BLOCKS];
    bit                    share;
    logic [CFG_DATA_W-1:0] count;
    grant_t                pending_grants[$];
    int                    errors;
    int                    reported;

    function new();
      foreach (sizes[j]) begin
        sizes[j] = '0;
        taken[j] = 1'b0;
      end
      share    = 1'b0;
      count    = COUNT_RST;
      errors   = 0;
      reported = 0;
    endfunction

    function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SHARE) begin
        share = data[0];
      end else if (idx == REG_COUNT) begin
        count = data;
      end
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic [LIDX_W-1:0] idx,
                               logic [REQ_W-1:0] size);
      grant_t      g;
      int unsigned n;
      longint      inner;
      longint      outer;
      int          best;
      bit          found;
      n           = (count > BLOCKS) ? BLOCKS : count;
      g.status    = STATUS_DONE;
      g.chosen    = '0;
      g.remaining = '0;
      if (op == OP_LOAD) begin
        if (idx < n) begin
          sizes[idx]  = size;
          taken[idx]  = 1'b0;
          g.chosen    = idx;
          g.remaining = size;
        end else begin
          g.status = STATUS_BAD_INDEX;
        end
      end else begin
        found = 1'b0;
        best  = 0;
        // >= on the size keeps the last of equal candidates
        for (int j = 0; j < n; j++) begin
          if ((share || !taken[j]) && sizes[j] >= size) begin
            if (!found || sizes[j] >= sizes[best]) begin
              best  = j;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          sizes[best] = sizes[best] - size;
          taken[best] = 1'b1;
          g.chosen    = CHOSEN_W'(best);
          g.remaining = sizes[best];
        end else begin
          g.status = STATUS_NO_FIT;
        end
      end
      inner = 0;
      outer = 0;
      for (int j = 0; j < n; j++) begin
        if (taken[j]) inner += sizes[j];
        else outer += sizes[j];
      end
      g.inner = (inner > SUM_MAX) ? SUM_MAX : FRAG_W'(inner);
      g.outer = (outer > SUM_MAX) ? SUM_MAX : FRAG_W'(outer);
      pending_grants.push_back(g);
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        end
      end
    endfunction

    function void match_result(logic [STATUS_W-1:0] status, logic [CHOSEN_W-1:0] chosen,
                               logic [REM_W-1:0] remaining, logic [FRAG_W-1:0] inner,
                               logic [FRAG_W-1:0] outer);
      grant_t g;
      if (pending_grants.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: result with none expected, expected nothing actual status %0d",
                   $time, status);
        end
        return;
      end
      g = pending_grants.pop_front();
      compare_field("status", g.status, status);
      compare_field("chosen_block", g.chosen, chosen);
      compare_field("remaining_size", g.remaining, remaining);
      compare_field("internal_frag", g.inner, inner);
      compare_field("external_frag", g.outer, outer);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  wfba_req_if req_if ();
  wfba_rsp_if rsp_if ();
  wfba_cfg_if cfg_if ();

  worst_fit_block_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  alloc_tracker sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // All handshakes are observed here so request and result ordering is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.apply_reg_write(cfg_if.index, cfg_if.data);
      if (req_if.valid && req_if.ready)
        sb.take_request(req_if.operation, req_if.load_index, req_if.size_value);
      if (rsp_if.valid && rsp_if.ready)
        sb.match_result(rsp_if.status, rsp_if.chosen_block, rsp_if.remaining_size,
                        rsp_if.internal_frag, rsp_if.external_frag);
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_if.valid && cfg_if.ready) || (req_if.valid && req_if.ready) ||
        (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic issue_request(logic [OP_W-1:0] op, logic [LIDX_W-1:0] idx,
                               logic [REQ_W-1:0] size);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.operation  = op;
    req_if.load_index = idx;
    req_if.size_value = size;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Drain all outstanding grants, then give the scan chain time to empty.
  task automatic settle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.pending_grants.size() != 0) @(posedge clk_i);
    repeat (BLOCKS + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] pick_size(bit for_load);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return REQ_W'($urandom);
      3:       return for_load ? REQ_W'($urandom) : REQ_W'($urandom_range(0, 200));
      default: return REQ_W'($urandom_range(0, for_load ? 4000 : 1500));
    endcase
  endfunction

  function automatic logic [LIDX_W-1:0] pick_index(int n_eff);
    if (n_eff == 0 || $urandom_range(5) == 0) return LIDX_W'($urandom);
    return LIDX_W'($urandom_range(0, n_eff - 1));
  endfunction

  // Block counts per phase; zero and values past the table are legal too.
  function automatic logic [CFG_DATA_W-1:0] phase_count(int p);
    case (p)
      2:       return 7'd1;
      3:       return 7'd2;
      4, 5:    return CFG_DATA_W'($urandom_range(3, 63));
      6:       return 7'd127;
      7:       return 7'd0;
      9:       return 7'd65;
      10:      return 7'd32;
      default: return 7'd64;
    endcase
  endfunction

  initial begin
    int                    sent;
    int                    burst;
    int                    n_eff;
    logic [CFG_DATA_W-1:0] cnt;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_LOAD;
    req_if.load_index = '0;
    req_if.size_value = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_SHARE;
    cfg_if.data       = '0;
    sb = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, ties, exclusive exhaustion, reload of a taken block
    issue_request(OP_ALLOC, 6'd63, 16'd0);
    issue_request(OP_LOAD, 6'd0, 16'hFFFF);
    issue_request(OP_LOAD, 6'd63, 16'hFFFF);
    issue_request(OP_LOAD, 6'd21, 16'd1000);
    issue_request(OP_LOAD, 6'd42, 16'h5555);
    issue_request(OP_LOAD, 6'd5, 16'd0);
    issue_request(OP_ALLOC, 6'd0, 16'hFFFF);
    issue_request(OP_ALLOC, 6'd0, 16'hFFFF);
    issue_request(OP_ALLOC, 6'd0, 16'hFFFF);
    issue_request(OP_ALLOC, 6'd0, 16'd1);
    issue_request(OP_ALLOC, 6'd0, 16'd0);
    issue_request(OP_LOAD, 6'd63, 16'hAAAA);
    settle();
    // Shared mode over a short table: repeated splits and out-of-range loads
    write_reg(REG_SHARE, 7'h7F);
    write_reg(REG_COUNT, 7'd10);
    issue_request(OP_LOAD, 6'd10, 16'd500);
    issue_request(OP_LOAD, 6'd63, 16'd500);
    issue_request(OP_LOAD, 6'd9, 16'd300);
    issue_request(OP_ALLOC, 6'd0, 16'd100);
    issue_request(OP_ALLOC, 6'd0, 16'd100);
    issue_request(OP_ALLOC, 6'd0, 16'd100);
    issue_request(OP_ALLOC, 6'd0, 16'd1);
    issue_request(OP_ALLOC, 6'd0, 16'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      cnt = phase_count(p);
      write_reg(REG_SHARE, {6'($urandom), 1'(p % 2)});
      write_reg(REG_COUNT, cnt);
      n_eff = (cnt > BLOCKS) ? BLOCKS : cnt;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(7) == 0) begin
          issue_request(OP_W'($urandom), LIDX_W'($urandom), REQ_W'($urandom));
          sent++;
        end else begin
          // a few loads to refill the table, then a run of allocations
          burst = $urandom_range(1, 6);
          for (int i = 0; i < burst; i++) begin
            issue_request(OP_LOAD, pick_index(n_eff), pick_size(1'b1));
            sent++;
          end
          burst = $urandom_range(1, 8);
          for (int i = 0; i < burst; i++) begin
            issue_request(OP_ALLOC, LIDX_W'($urandom), pick_size(1'b0));
            sent++;
          end
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/wfba_pkg.sv
design/wfba_intf.sv
design/wfba_cell.sv
design/wfba_ctrl.sv
design/worst_fit_block_allocator.sv
bench/tb_top.sv
